// ===== hw/rtl/bcme_pkg.sv =====
`default_nettype none

package bcme_pkg;

  localparam int BLOCK_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_DECRYPT = 3'd1;
  localparam logic [2:0] REG_PAD_EN  = 3'd2;
  localparam logic [2:0] REG_KEY     = 3'd3;
  localparam logic [2:0] REG_IV      = 3'd4;

  localparam logic [1:0] JOB_BLOCK = 2'd0;
  localparam logic [1:0] JOB_CFB   = 2'd1;
  localparam logic [1:0] JOB_ERR   = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_FILL = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic       pad_block;
    logic       msg_end;
    logic       load_iv;
  } bcme_ctl_t;

  function automatic logic [7:0] word_byte(input logic [63:0] w, input logic [2:0] k);
    logic [2:0] sel;
    sel = 3'd7 - k;
    return w[8*sel +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcme_queue.sv =====
`default_nettype none

module bcme_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bcme_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNTW'(DEPTH));

endmodule

`default_nettype wire

// ===== hw/rtl/bcme_front.sv =====
`default_nettype none

module bcme_front #(
  parameter int BLOCK_BYTES = bcme_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [7:0]                            in_byte,
  input  wire logic                                  in_message_end,
  input  wire logic [1:0]                            cfg_mode,
  input  wire logic                                  cfg_decrypt,
  input  wire logic                                  cfg_pad_en,
  input  wire logic [63:0]                           cfg_iv,
  input  wire logic                                  q_full,
  output logic                                       push,
  output bcme_pkg::bcme_ctl_t                        job_ctl,
  output logic [$clog2(BLOCK_BYTES+2)-1:0]           job_count,
  output logic [BLOCK_BYTES-1:0][7:0]                job_data,
  output logic [BLOCK_BYTES-1:0][7:0]                job_iv
);

  import bcme_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 2);
  localparam int IW = $clog2(BLOCK_BYTES);

  logic [BLOCK_BYTES-1:0][7:0] blk_r, blk_nxt;
  logic [BLOCK_BYTES-1:0][7:0] iv_hold_r;
  logic [IW-1:0]               fill_r, fill_nxt;
  logic                        at_start_r;
  logic                        load_pend_r;

  logic                        accept;
  logic [IW-1:0]               fc;
  logic [CW-1:0]               fc_ext;
  logic                        padding;
  logic                        is_cfb;
  logic                        full;
  logic                        need;
  logic [BLOCK_BYTES-1:0][7:0] blk_w;
  logic [BLOCK_BYTES-1:0][7:0] pad_data;
  logic [BLOCK_BYTES-1:0][7:0] iv_exp;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    fc      = at_start_r ? '0 : fill_r;
    fc_ext  = CW'(fc);
    padding = !cfg_decrypt && cfg_pad_en;
    is_cfb  = (cfg_mode == MODE_CFB);
    full    = (fc == IW'(BLOCK_BYTES - 1));

    for (int k = 0; k < BLOCK_BYTES; k++) begin
      iv_exp[k] = word_byte(cfg_iv, 3'(k));
      blk_w[k]  = (IW'(k) == fc) ? in_byte : blk_r[k];
      if (CW'(k) < fc_ext) begin
        pad_data[k] = blk_r[k];
      end else if (CW'(k) == fc_ext) begin
        pad_data[k] = in_byte;
      end else if (CW'(k) == fc_ext + CW'(1)) begin
        pad_data[k] = PAD_MARK;
      end else begin
        pad_data[k] = PAD_FILL;
      end
    end

    job_ctl.kind      = JOB_BLOCK;
    job_ctl.pad_block = 1'b0;
    job_ctl.msg_end   = in_message_end;
    job_ctl.load_iv   = at_start_r || load_pend_r;
    job_count         = CW'(1);
    job_data          = blk_w;
    job_iv            = at_start_r ? iv_exp : iv_hold_r;
    need              = 1'b0;
    blk_nxt           = blk_w;
    fill_nxt          = full ? '0 : fc + IW'(1);

    if (is_cfb) begin
      job_ctl.kind = JOB_CFB;
      job_data     = '0;
      job_data[0]  = in_byte;
      need         = 1'b1;
      blk_nxt      = blk_r;
      if (in_message_end && padding) begin
        job_count = full ? CW'(BLOCK_BYTES + 1) : CW'(BLOCK_BYTES) - fc_ext;
      end
    end else if (full) begin
      need              = 1'b1;
      job_ctl.pad_block = in_message_end && padding;
    end else if (in_message_end) begin
      need = 1'b1;
      if (padding) begin
        job_data = pad_data;
      end else begin
        job_ctl.kind = JOB_ERR;
      end
    end

    if (in_message_end) begin
      fill_nxt = '0;
    end
  end

  assign push = accept && need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r       <= '0;
      fill_r      <= '0;
      at_start_r  <= 1'b1;
      load_pend_r <= 1'b0;
    end else if (accept) begin
      blk_r       <= blk_nxt;
      fill_r      <= fill_nxt;
      at_start_r  <= in_message_end;
      load_pend_r <= !need && (at_start_r || load_pend_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (at_start_r) begin
        iv_hold_r <= iv_exp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bcme_back.sv =====
`default_nettype none

module bcme_back #(
  parameter int BLOCK_BYTES = bcme_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_valid,
  input  wire bcme_pkg::bcme_ctl_t                   q_ctl,
  input  wire logic [$clog2(BLOCK_BYTES+2)-1:0]      q_count,
  input  wire logic [BLOCK_BYTES-1:0][7:0]           q_data,
  input  wire logic [BLOCK_BYTES-1:0][7:0]           q_iv,
  output logic                                       q_pop,
  input  wire logic [1:0]                            cfg_mode,
  input  wire logic                                  cfg_decrypt,
  input  wire logic [63:0]                           cfg_key,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [7:0]                                 out_byte,
  output logic                                       out_run_last,
  output logic                                       out_message_last,
  output logic                                       out_partial_block_error
);

  import bcme_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 2);
  localparam int IW = $clog2(BLOCK_BYTES);

  logic [BLOCK_BYTES-1:0][7:0] chain_r, chain_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        ph_r, ph_nxt;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_run_last_r;
  logic                        out_message_last_r;
  logic                        out_err_r;

  logic                        adv;
  logic                        first;
  logic                        last;
  logic                        err;
  logic                        blk_end;
  logic [BLOCK_BYTES-1:0][7:0] ch;
  logic [IW-1:0]               bi;
  logic [7:0]                  kb;
  logic [7:0]                  kb0;
  logic [7:0]                  din;
  logic [7:0]                  res;
  logic [7:0]                  fb;

  assign adv = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    first   = (idx_r == '0) && !ph_r;
    ch      = (first && q_ctl.load_iv) ? q_iv : chain_r;
    bi      = idx_r[IW-1:0];
    kb      = word_byte(cfg_key, 3'(idx_r));
    kb0     = word_byte(cfg_key, 3'd0);
    blk_end = (idx_r == CW'(BLOCK_BYTES - 1));
    chain_nxt = ch;
    din     = PAD_FILL;
    res     = '0;
    fb      = '0;
    err     = 1'b0;
    last    = 1'b1;

    unique case (q_ctl.kind)
      JOB_BLOCK: begin
        if (ph_r) begin
          din = (idx_r == '0) ? PAD_MARK : PAD_FILL;
        end else begin
          din = q_data[bi];
        end
        if (cfg_mode == MODE_CBC) begin
          res = din ^ kb ^ ch[bi];
          chain_nxt[bi] = cfg_decrypt ? din : res;
        end else begin
          res = din ^ kb;
        end
        last = blk_end && (ph_r || !q_ctl.pad_block);
      end
      JOB_CFB: begin
        if (idx_r == '0) begin
          din = q_data[0];
        end else if (idx_r == CW'(1)) begin
          din = PAD_MARK;
        end else begin
          din = PAD_FILL;
        end
        res = din ^ ch[0] ^ kb0;
        fb  = cfg_decrypt ? din : res;
        for (int k = 0; k < BLOCK_BYTES - 1; k++) begin
          chain_nxt[k] = ch[k+1];
        end
        chain_nxt[BLOCK_BYTES-1] = fb;
        last = (idx_r == q_count - CW'(1));
      end
      JOB_ERR: begin
        err = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase

    idx_nxt = idx_r;
    ph_nxt  = ph_r;
    if (adv) begin
      if (last) begin
        idx_nxt = '0;
        ph_nxt  = 1'b0;
      end else if ((q_ctl.kind == JOB_BLOCK) && blk_end) begin
        idx_nxt = '0;
        ph_nxt  = 1'b1;
      end else begin
        idx_nxt = idx_r + CW'(1);
      end
    end
  end

  assign q_pop = adv && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ph_r  <= ph_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain_r            <= chain_nxt;
      out_byte_r         <= res;
      out_run_last_r     <= last;
      out_message_last_r <= last && q_ctl.msg_end;
      out_err_r          <= err;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_byte                = out_byte_r;
  assign out_run_last            = out_run_last_r;
  assign out_message_last        = out_message_last_r;
  assign out_partial_block_error = out_err_r;

endmodule

`default_nettype wire

// ===== hw/rtl/block_cipher_mode_engine_core.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_*      input      in_valid/in_stall  in_byte, in_message_end
// out_*     output     out_valid/out_stall out_byte, out_run_last, out_message_last,
//                                          out_partial_block_error
// APB       input      psel/penable/pready paddr, pwrite, pwdata, prdata
//
// The front takes one input transaction per cycle unless stalled, handing work to the
// back via a two-entry job queue; the back emits one output per cycle unless stalled.
// A completed block yields BLOCK_BYTES outputs, twice that when a padding block
// follows, and a padded CFB end yields up to BLOCK_BYTES + 1 outputs.
// The input stalls only while the job queue is full; the back stalls on out_stall.
// Synchronous active-low reset: pad_enable to one, mode, decrypt, key and iv to zero.

module block_cipher_mode_engine_core #(
  parameter int BLOCK_BYTES = bcme_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = bcme_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_message_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_message_last,
  output logic             out_partial_block_error,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  import bcme_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 2);
  localparam int QW = $bits(bcme_ctl_t) + CW + 2 * BLOCK_BYTES * 8;

  logic [1:0]  mode_r;
  logic        decrypt_r;
  logic        pad_en_r;
  logic [63:0] key_r;
  logic [63:0] iv_r;
  logic [2:0]  reg_idx;

  bcme_ctl_t                   f_ctl, q_ctl;
  logic [CW-1:0]               f_count, q_count;
  logic [BLOCK_BYTES-1:0][7:0] f_data, q_data;
  logic [BLOCK_BYTES-1:0][7:0] f_iv, q_iv;
  logic [QW-1:0]               q_wdata, q_rdata;
  logic                        q_push, q_pop, q_empty, q_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ECB;
      decrypt_r <= 1'b0;
      pad_en_r  <= 1'b1;
      key_r     <= '0;
      iv_r      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MODE:    mode_r    <= pwdata[1:0];
        REG_DECRYPT: decrypt_r <= pwdata[0];
        REG_PAD_EN:  pad_en_r  <= pwdata[0];
        REG_KEY:     key_r     <= pwdata;
        REG_IV:      iv_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = 64'(mode_r);
      REG_DECRYPT: prdata = 64'(decrypt_r);
      REG_PAD_EN:  prdata = 64'(pad_en_r);
      REG_KEY:     prdata = key_r;
      REG_IV:      prdata = iv_r;
      default:     prdata = '0;
    endcase
  end

  bcme_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .cfg_mode       (mode_r),
    .cfg_decrypt    (decrypt_r),
    .cfg_pad_en     (pad_en_r),
    .cfg_iv         (iv_r),
    .q_full         (q_full),
    .push           (q_push),
    .job_ctl        (f_ctl),
    .job_count      (f_count),
    .job_data       (f_data),
    .job_iv         (f_iv)
  );

  assign q_wdata = {f_ctl, f_count, f_data, f_iv};
  assign {q_ctl, q_count, q_data, q_iv} = q_rdata;

  bcme_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  bcme_back #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_valid                 (!q_empty),
    .q_ctl                   (q_ctl),
    .q_count                 (q_count),
    .q_data                  (q_data),
    .q_iv                    (q_iv),
    .q_pop                   (q_pop),
    .cfg_mode                (mode_r),
    .cfg_decrypt             (decrypt_r),
    .cfg_key                 (key_r),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_byte                (out_byte),
    .out_run_last            (out_run_last),
    .out_message_last        (out_message_last),
    .out_partial_block_error (out_partial_block_error)
  );

endmodule

`default_nettype wire

// ===== tb/block_cipher_mode_engine_core_test.sv =====
`default_nettype none

module block_cipher_mode_engine_core_test;
  import bcme_pkg::*;

  localparam int NB = BLOCK_BYTES_DEF;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 480;

  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_last;
    logic       err;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic in_message_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_run_last;
  logic out_message_last;
  logic out_partial_block_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = 6'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic pready;

  logic no_idle = 1'b0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  // Shadow of the engine: configuration and cipher state.
  logic [1:0] cfg_mode = MODE_ECB;
  logic cfg_decrypt = 1'b0;
  logic cfg_pad = 1'b1;
  logic [63:0] cfg_key = 64'd0;
  logic [63:0] cfg_iv = 64'd0;
  logic [7:0] held [NB] = '{default: 8'h00};
  logic [7:0] chain [NB] = '{default: 8'h00};
  int unsigned held_count = 0;
  logic msg_start = 1'b1;
  cipher_out_t burst[$];
  cipher_out_t expected_bytes[$];

  block_cipher_mode_engine_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_message_end(in_message_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_run_last(out_run_last),
    .out_message_last(out_message_last),
    .out_partial_block_error(out_partial_block_error),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] lane(input logic [63:0] w, input int i);
    return w[8 * (7 - (i % 8)) +: 8];
  endfunction

  task automatic cipher_block(input logic cbc);
    logic [7:0] o;
    logic [7:0] kb;
    for (int i = 0; i < NB; i++) begin
      kb = lane(cfg_key, i);
      if (!cbc) begin
        o = held[i] ^ kb;
      end else if (!cfg_decrypt) begin
        o = held[i] ^ chain[i] ^ kb;
        chain[i] = o;
      end else begin
        o = held[i] ^ kb ^ chain[i];
        chain[i] = held[i];
      end
      burst.push_back('{o, 1'b0, 1'b0, 1'b0});
    end
    held_count = 0;
  endtask

  task automatic cfb_byte(input logic [7:0] b);
    logic [7:0] o;
    logic [7:0] fb;
    o = b ^ chain[0] ^ lane(cfg_key, 0);
    fb = cfg_decrypt ? b : o;
    for (int i = 0; i < NB - 1; i++) chain[i] = chain[i + 1];
    chain[NB - 1] = fb;
    held_count = (held_count + 1) % NB;
    burst.push_back('{o, 1'b0, 1'b0, 1'b0});
  endtask

  task automatic predict_bytes(input logic [7:0] b, input logic e);
    logic padding;
    padding = !cfg_decrypt && cfg_pad;
    burst.delete();
    if (msg_start) begin
      for (int i = 0; i < NB; i++) chain[i] = lane(cfg_iv, i);
      held_count = 0;
      msg_start = 1'b0;
    end
    if (cfg_mode == MODE_CFB) begin
      cfb_byte(b);
      if (e && padding) begin
        cfb_byte(PAD_MARK);
        while (held_count != 0) cfb_byte(PAD_FILL);
      end
    end else begin
      held[held_count % NB] = b;
      held_count++;
      if (held_count >= NB) cipher_block(cfg_mode == MODE_CBC);
      if (e) begin
        if (padding) begin
          held[held_count] = PAD_MARK;
          held_count++;
          while (held_count < NB) begin
            held[held_count] = PAD_FILL;
            held_count++;
          end
          cipher_block(cfg_mode == MODE_CBC);
        end else if (held_count != 0) begin
          held_count = 0;
          burst.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
        end
      end
    end
    if (e) begin
      msg_start = 1'b1;
      held_count = 0;
    end
    if (burst.size() > 0) begin
      burst[burst.size() - 1].run_last = 1'b1;
      if (e) burst[burst.size() - 1].msg_last = 1'b1;
    end
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Follows register writes, accepted inputs and accepted outputs at each edge.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_MODE: cfg_mode = pwdata[1:0];
          REG_DECRYPT: cfg_decrypt = pwdata[0];
          REG_PAD_EN: cfg_pad = pwdata[0];
          REG_KEY: cfg_key = pwdata;
          REG_IV: cfg_iv = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_bytes(in_byte, in_message_end);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %0h", out_byte);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_run_last", 8'(want.run_last), 8'(out_run_last));
          check_field("out_message_last", 8'(want.msg_last), 8'(out_message_last));
          check_field("out_partial_block_error", 8'(want.err),
                      8'(out_partial_block_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !no_idle && ($urandom_range(99) < 34);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("block_cipher_mode_engine_core_test: errors");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic e);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_message_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] idx, input logic [63:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want) begin
      $error("prdata mismatch at register %0d: expected %0h, got %0h", idx, want, prdata);
      failures++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] m, input logic d, input logic p,
                           input logic [63:0] k, input logic [63:0] v);
    wait_idle();
    reg_write(REG_MODE, {62'd0, m});
    reg_write(REG_DECRYPT, {63'd0, d});
    reg_write(REG_PAD_EN, {63'd0, p});
    reg_write(REG_KEY, k);
    reg_write(REG_IV, v);
  endtask

  task automatic test_register_access();
    reg_write(REG_MODE, '1);
    reg_write(REG_DECRYPT, '1);
    reg_write(REG_PAD_EN, '0);
    reg_write(REG_KEY, '1);
    reg_write(REG_IV, '1);
    reg_read(REG_MODE, 64'd3);
    reg_read(REG_DECRYPT, 64'd1);
    reg_read(REG_PAD_EN, 64'd0);
    reg_read(REG_KEY, '1);
    reg_read(REG_IV, '1);
    reg_write(REG_KEY, 64'h0123_4567_89ab_cdef);
    reg_read(REG_KEY, 64'h0123_4567_89ab_cdef);
  endtask

  task automatic test_block_padding();
    configure(MODE_ECB, 1'b0, 1'b1, '1, '0);
    for (int i = 0; i < NB; i++) send_item((i % 2) ? 8'hff : 8'h00, i == NB - 1);
    configure(MODE_CBC, 1'b0, 1'b1, 64'h8000_0000_0000_0001, '1);
    send_item(8'hff, 1'b1);
  endtask

  task automatic test_partial_block_drop();
    configure(MODE_CBC, 1'b1, 1'b1, 64'h5a5a_a5a5_0f0f_f0f0, 64'h1122_3344_5566_7788);
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    send_item(8'h56, 1'b1);
    configure(MODE_ECB, 1'b0, 1'b0, '1, '0);
    send_item(8'h80, 1'b0);
    send_item(8'h7f, 1'b1);
  endtask

  task automatic test_cfb_stream();
    configure(MODE_CFB, 1'b0, 1'b1, 64'hc300_0000_0000_0000, 64'hdead_beef_0bad_f00d);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    configure(MODE_CFB, 1'b1, 1'b1, '1, '1);
    send_item(8'ha5, 1'b1);
  endtask

  task automatic test_mode_three();
    configure(MODE_RESERVED, 1'b0, 1'b1, 64'h0f1e_2d3c_4b5a_6978, '0);
    send_item(8'h3c, 1'b1);
  endtask

  task automatic test_config_mid_message();
    configure(MODE_ECB, 1'b0, 1'b1, 64'h1111_2222_3333_4444, 64'haaaa_bbbb_cccc_dddd);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    configure(MODE_CBC, 1'b0, 1'b1, 64'h9999_8888_7777_6666, 64'h0000_0000_ffff_ffff);
    send_item(8'h03, 1'b0);
    send_item(8'h04, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned phase;
    int len;
    logic [1:0] m;
    logic [63:0] k;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      m = ($urandom_range(9) == 0) ? MODE_RESERVED : 2'($urandom_range(2));
      case ($urandom_range(3))
        0: k = '0;
        1: k = '1;
        default: k = {$urandom, $urandom};
      endcase
      configure(m, 1'($urandom_range(1)), 1'($urandom_range(1)), k, {$urandom, $urandom});
      no_idle = (phase == 2);
      phase_sent = 0;
      while (phase_sent < 40) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 17);
        send_message(len);
        phase_sent += len;
        if (phase == 4 && phase_sent >= 20 && phase_sent < 20 + len) begin
          in_valid <= 1'b0;
          while (expected_bytes.size() != 0) @(posedge clk);
        end
      end
      sent += phase_sent;
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_block_padding();
    test_partial_block_drop();
    test_cfb_stream();
    test_mode_three();
    test_config_mid_message();
    test_random_traffic();
    wait_idle();
    if (failures == 0) begin
      $display("block_cipher_mode_engine_core_test: clean");
    end else begin
      $display("block_cipher_mode_engine_core_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
